### hw/rtl/pbry_pkg.sv
// Shared constants, types and the ratio saturation helper for the price bar block.
package pbry_pkg;

  localparam int WINDOW_MAX_DEF = 12;
  localparam int PRICE_BITS_DEF = 32;

  // Q16.16 ratios: 16 fraction bits, 32 quotient bits.
  localparam int FRAC_BITS = 16;
  localparam int QBITS     = 32;

  localparam logic [QBITS-1:0] RATIO_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [QBITS-1:0] RATIO_NEG_MAX = 32'h8000_0000;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int WL_W       = 4;
  localparam int FLOOR_W    = 32;

  localparam logic [WL_W-1:0]    WL_RESET    = 4'd12;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 32'h0001_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADJ_CLOSE_FLOOR = 1'b1;

  typedef struct packed {
    logic done;
    logic den_zero;
    logic over;
  } div_stat_t;

  typedef struct packed {
    logic [QBITS-1:0] val;
    logic             fault;
  } ratio_t;

  // Clamp a finished quotient against its limit; flags zero divisor and overflow.
  function automatic ratio_t sat_ratio(input logic [QBITS-1:0] q, input div_stat_t st,
                                       input logic num_nz, input logic [QBITS-1:0] lim);
    ratio_t r;
    r.fault = 1'b1;
    if (st.den_zero) begin
      r.val = num_nz ? lim : '0;
    end else if (st.over || (q > lim)) begin
      r.val = lim;
    end else begin
      r.val   = q;
      r.fault = 1'b0;
    end
    return r;
  endfunction

endpackage

### hw/rtl/pbry_div.sv
// Bit-serial restoring divider: (num << 16) / den, one quotient bit per cycle.
module pbry_div #(
  parameter int PRICE_BITS = pbry_pkg::PRICE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [PRICE_BITS-1:0]        num,
  input  logic [PRICE_BITS-1:0]        den,
  output pbry_pkg::div_stat_t          stat,
  output logic [pbry_pkg::QBITS-1:0]   quo
);

  localparam int PW  = PRICE_BITS;
  localparam int QB  = pbry_pkg::QBITS;
  localparam int FB  = pbry_pkg::FRAC_BITS;
  localparam int NW  = PW + FB;
  localparam int CNW = $clog2(QB);

  logic [NW-1:0]  n_w;
  logic [PW-1:0]  rem_init;
  logic [PW:0]    trial;
  logic           qbit;

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic           dz_r, dz_nxt;
  logic           ov_r, ov_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0]  rem_r, rem_nxt;
  logic [PW-1:0]  den_r, den_nxt;
  logic [QB-1:0]  dvd_r, dvd_nxt;

  assign n_w      = {num, {FB{1'b0}}};
  assign rem_init = PW'(n_w >> QB);
  assign trial    = {rem_r, dvd_r[QB-1]};
  assign qbit     = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    dz_nxt   = dz_r;
    ov_nxt   = ov_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    dvd_nxt  = dvd_r;
    if (start) begin
      dz_nxt   = (den == '0);
      ov_nxt   = (den != '0) && (rem_init >= den);
      busy_nxt = (den != '0) && (rem_init < den);
      done_nxt = (den == '0) || (rem_init >= den);
      cnt_nxt  = '0;
      rem_nxt  = rem_init;
      den_nxt  = den;
      dvd_nxt  = n_w[QB-1:0];
    end else if (busy_r) begin
      rem_nxt = qbit ? PW'(trial - {1'b0, den_r}) : trial[PW-1:0];
      // low dividend bits leave at the top, quotient bits enter at the bottom
      dvd_nxt = {dvd_r[QB-2:0], qbit};
      cnt_nxt = cnt_r + CNW'(1);
      if (cnt_r == CNW'(QB - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      dz_r   <= 1'b0;
      ov_r   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      dz_r   <= dz_nxt;
      ov_r   <= ov_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    dvd_r <= dvd_nxt;
  end

  assign stat.done     = done_r;
  assign stat.den_zero = dz_r;
  assign stat.over     = ov_r;
  assign quo           = dvd_r;

endmodule

### hw/rtl/pbry_div3.sv
// Bit-serial divide by three for the mid price, one sum bit per cycle.
module pbry_div3 #(
  parameter int PRICE_BITS = pbry_pkg::PRICE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [PRICE_BITS+1:0] sum,
  output logic                  busy,
  output logic [PRICE_BITS-1:0] quo
);

  localparam int PW  = PRICE_BITS;
  localparam int SW  = PW + 2;
  localparam int CNW = $clog2(SW);

  logic [2:0]     t;
  logic           qbit;

  logic           busy_r, busy_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  logic [1:0]     rem_r, rem_nxt;
  logic [SW-1:0]  sh_r, sh_nxt;

  assign t    = {rem_r, sh_r[SW-1]};
  assign qbit = (t >= 3'd3);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      sh_nxt   = sum;
    end else if (busy_r) begin
      rem_nxt = qbit ? 2'(t - 3'd3) : t[1:0];
      sh_nxt  = {sh_r[SW-2:0], qbit};
      cnt_nxt = cnt_r + CNW'(1);
      if (cnt_r == CNW'(SW - 1))
        busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
  end

  // sum < 3 * 2^PW, so the quotient fits the price width
  assign busy = busy_r;
  assign quo  = sh_r[PW-1:0];

endmodule

### hw/rtl/pbry_win.sv
// Shift line of recent highs and lows with a one-entry-per-cycle range scan.
module pbry_win #(
  parameter int WINDOW_MAX = pbry_pkg::WINDOW_MAX_DEF,
  parameter int PRICE_BITS = pbry_pkg::PRICE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  input  logic [PRICE_BITS-1:0]            hi,
  input  logic [PRICE_BITS-1:0]            lo,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]  len,
  output logic                             busy,
  output logic                             levels_valid,
  output logic [PRICE_BITS-1:0]            span
);

  localparam int PW = PRICE_BITS;
  localparam int LW = $clog2(WINDOW_MAX + 1);
  localparam int IW = $clog2(WINDOW_MAX);

  logic [PW-1:0] hi_r [WINDOW_MAX];
  logic [PW-1:0] lo_r [WINDOW_MAX];
  logic [PW-1:0] rd_hi, rd_lo;
  logic [LW-1:0] seen_nxt;
  logic          valid_nxt;

  logic [LW-1:0] seen_r;
  logic          busy_r;
  logic          valid_r;
  logic [IW-1:0] idx_r;
  logic [IW-1:0] last_r;
  logic [PW-1:0] mx_r;
  logic [PW-1:0] mn_r;

  assign rd_hi     = hi_r[idx_r];
  assign rd_lo     = lo_r[idx_r];
  assign seen_nxt  = (seen_r == LW'(WINDOW_MAX)) ? seen_r : seen_r + LW'(1);
  assign valid_nxt = (seen_nxt >= len);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      idx_r   <= '0;
      last_r  <= '0;
    end else if (push) begin
      seen_r  <= seen_nxt;
      valid_r <= valid_nxt;
      busy_r  <= valid_nxt && (len > LW'(1));
      idx_r   <= IW'(1);
      last_r  <= IW'(len - LW'(1));
    end else if (busy_r) begin
      if (idx_r == last_r)
        busy_r <= 1'b0;
      else
        idx_r <= idx_r + IW'(1);
    end
  end

  // newest entry sits at index 0; the scan starts from the incoming bar
  always_ff @(posedge clk) begin
    if (push) begin
      for (int k = WINDOW_MAX - 1; k > 0; k--) begin
        hi_r[k] <= hi_r[k-1];
        lo_r[k] <= lo_r[k-1];
      end
      hi_r[0] <= hi;
      lo_r[0] <= lo;
      mx_r    <= hi;
      mn_r    <= lo;
    end else if (busy_r) begin
      if (rd_hi > mx_r)
        mx_r <= rd_hi;
      if (rd_lo < mn_r)
        mn_r <= rd_lo;
    end
  end

  assign busy         = busy_r;
  assign levels_valid = valid_r;
  assign span         = (mx_r > mn_r) ? (mx_r - mn_r) : '0;

endmodule

### hw/rtl/price_bar_range_and_yield.sv
// Top level of the price bar range and yield block.
// Takes one price bar per beat and returns one result beat per bar. A bar is
// worked on before the next bar is taken: one bit-serial divider computes the
// day yield and then the volatility, 32 quotient bits each at one bit per cycle.
// A division by zero or one whose quotient overflows finishes early; the bar
// then still waits for the bit-serial mid price divide and the range scan,
// whichever finishes later. A finished result sits in the output register while
// the next bar is taken. Configuration writes are taken at any time (cfg_ready
// is always high) but should only be issued while idle.
module price_bar_range_and_yield #(
  parameter int WINDOW_MAX = pbry_pkg::WINDOW_MAX_DEF,
  parameter int PRICE_BITS = pbry_pkg::PRICE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,

  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [PRICE_BITS-1:0]               in_bar_high,
  input  logic [PRICE_BITS-1:0]               in_bar_low,
  input  logic [PRICE_BITS-1:0]               in_bar_close,
  input  logic [PRICE_BITS-1:0]               in_adjusted_close,

  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [PRICE_BITS-1:0]               out_mid_price,
  output logic signed [PRICE_BITS:0]          out_support_level,
  output logic [PRICE_BITS:0]                 out_pressure_level,
  output logic                                out_levels_valid,
  output logic signed [pbry_pkg::QBITS-1:0]   out_day_yield,
  output logic [pbry_pkg::QBITS-2:0]          out_day_volatility,
  output logic                                out_ratio_fault,

  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pbry_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pbry_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int PW   = PRICE_BITS;
  localparam int QB   = pbry_pkg::QBITS;
  localparam int WLW  = pbry_pkg::WL_W;
  localparam int FLW  = pbry_pkg::FLOOR_W;
  localparam int LW   = $clog2(WINDOW_MAX + 1);
  localparam int LENW = (LW > WLW) ? LW : WLW;
  localparam int CW   = (PW > FLW) ? PW : FLW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_YLD  = 4'b0010,
    S_VOL  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [WLW-1:0] wl_r;
  logic [FLW-1:0] floor_r;

  // per-bar operands and partial results
  logic           have_prev_r;
  logic [PW-1:0]  prev_eff_r;
  logic [PW-1:0]  prev_cl_r;
  logic           yld_neg_r;
  logic           yld_nz_r;
  logic [PW-1:0]  vol_num_r;
  logic [PW-1:0]  vol_den_r;
  logic [QB-1:0]  yld_r;
  logic [QB-2:0]  vol_r;
  logic           flt_r;

  // output register
  logic                 out_valid_r;
  logic [PW-1:0]        out_mid_r;
  logic signed [PW:0]   out_sup_r;
  logic [PW:0]          out_prs_r;
  logic                 out_lv_r;
  logic [QB-1:0]        out_yld_r;
  logic [QB-2:0]        out_vol_r;
  logic                 out_flt_r;

  logic            in_acc;
  logic            out_take;
  logic [LENW-1:0] wl_ext;
  logic [LENW-1:0] len_ext;
  logic [LW-1:0]   len;
  logic [PW-1:0]   eff;
  logic [PW-1:0]   prev_eff;
  logic [PW-1:0]   prev_cl;
  logic            yld_neg;
  logic [PW-1:0]   yld_mag;
  logic [PW-1:0]   vnum;
  logic [PW+1:0]   bar_sum;

  logic                 div_start;
  logic [PW-1:0]        div_num;
  logic [PW-1:0]        div_den;
  pbry_pkg::div_stat_t  div_stat;
  logic [QB-1:0]        div_quo;
  pbry_pkg::ratio_t     rat;
  logic                 rat_nz;
  logic [QB-1:0]        rat_lim;

  logic          mid_busy;
  logic [PW-1:0] mid;
  logic          win_busy;
  logic          win_valid;
  logic [PW-1:0] span;
  logic          res_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r    <= pbry_pkg::WL_RESET;
      floor_r <= pbry_pkg::FLOOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pbry_pkg::CFG_WINDOW_LENGTH:   wl_r    <= cfg_data[WLW-1:0];
        pbry_pkg::CFG_ADJ_CLOSE_FLOOR: floor_r <= cfg_data[FLW-1:0];
        default: ;
      endcase
    end
  end

  // window length of zero acts as one, above the storage depth as the depth
  assign wl_ext  = LENW'(wl_r);
  assign len_ext = (wl_ext == '0) ? LENW'(1) :
                   (wl_ext > LENW'(WINDOW_MAX)) ? LENW'(WINDOW_MAX) : wl_ext;
  assign len     = len_ext[LW-1:0];

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;

  assign eff      = (CW'(in_adjusted_close) > CW'(floor_r)) ? in_adjusted_close
                                                            : in_bar_close;
  assign prev_eff = have_prev_r ? prev_eff_r : eff;
  assign prev_cl  = have_prev_r ? prev_cl_r : in_bar_close;
  assign yld_neg  = (eff < prev_eff);
  assign yld_mag  = yld_neg ? (prev_eff - eff) : (eff - prev_eff);
  assign vnum     = (in_bar_high > in_bar_low) ? (in_bar_high - in_bar_low) : '0;
  assign bar_sum  = (PW+2)'(in_bar_high) + (PW+2)'(in_bar_low) + (PW+2)'(in_bar_close);

  // yield division starts with the bar, volatility right after it
  assign div_start = in_acc || ((state_r == S_YLD) && div_stat.done);
  assign div_num   = (state_r == S_IDLE) ? yld_mag : vol_num_r;
  assign div_den   = (state_r == S_IDLE) ? prev_eff : vol_den_r;

  assign rat_nz  = (state_r == S_YLD) ? yld_nz_r : (vol_num_r != '0);
  assign rat_lim = ((state_r == S_YLD) && yld_neg_r) ? pbry_pkg::RATIO_NEG_MAX
                                                     : pbry_pkg::RATIO_POS_MAX;
  assign rat     = pbry_pkg::sat_ratio(div_quo, div_stat, rat_nz, rat_lim);

  assign res_load = (state_r == S_DONE) && !mid_busy && !win_busy &&
                    (!out_valid_r || !out_stall);

  pbry_div #(
    .PRICE_BITS(PRICE_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  pbry_div3 #(
    .PRICE_BITS(PRICE_BITS)
  ) u_div3 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .sum   (bar_sum),
    .busy  (mid_busy),
    .quo   (mid)
  );

  pbry_win #(
    .WINDOW_MAX(WINDOW_MAX),
    .PRICE_BITS(PRICE_BITS)
  ) u_win (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (in_acc),
    .hi           (in_bar_high),
    .lo           (in_bar_low),
    .len          (len),
    .busy         (win_busy),
    .levels_valid (win_valid),
    .span         (span)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_YLD;
      S_YLD:  if (div_stat.done) state_nxt = S_VOL;
      S_VOL:  if (div_stat.done) state_nxt = S_DONE;
      S_DONE: if (res_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      have_prev_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc)
        have_prev_r <= 1'b1;
      if (res_load)
        out_valid_r <= 1'b1;
      else if (out_take)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      prev_eff_r <= eff;
      prev_cl_r  <= in_bar_close;
      yld_neg_r  <= yld_neg;
      yld_nz_r   <= (yld_mag != '0);
      vol_num_r  <= vnum;
      vol_den_r  <= prev_cl;
    end
    if ((state_r == S_YLD) && div_stat.done) begin
      yld_r <= yld_neg_r ? (QB'(0) - rat.val) : rat.val;
      flt_r <= rat.fault;
    end
    if ((state_r == S_VOL) && div_stat.done) begin
      vol_r <= rat.val[QB-2:0];
      flt_r <= flt_r | rat.fault;
    end
    if (res_load) begin
      out_mid_r <= mid;
      out_sup_r <= win_valid ? $signed((PW+1)'(mid) - (PW+1)'(span)) : '0;
      out_prs_r <= win_valid ? ((PW+1)'(mid) + (PW+1)'(span)) : '0;
      out_lv_r  <= win_valid;
      out_yld_r <= yld_r;
      out_vol_r <= vol_r;
      out_flt_r <= flt_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mid_price      = out_mid_r;
  assign out_support_level  = out_sup_r;
  assign out_pressure_level = out_prs_r;
  assign out_levels_valid   = out_lv_r;
  assign out_day_yield      = $signed(out_yld_r);
  assign out_day_volatility = out_vol_r;
  assign out_ratio_fault    = out_flt_r;

endmodule

### hw/rtl/pbry_chk.sv
// Port-level checks for the price bar block, bound to its top level.
module pbry_chk #(
  parameter int PRICE_BITS = pbry_pkg::PRICE_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [PRICE_BITS-1:0]       out_mid_price,
  input logic signed [PRICE_BITS:0]  out_support_level,
  input logic [PRICE_BITS:0]         out_pressure_level,
  input logic                        out_levels_valid
);

  // a taken bar keeps the input side stalled while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken in back-to-back cycles");

  a_levels_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_levels_valid) |->
      (out_support_level == '0) && (out_pressure_level == '0))
    else $error("levels nonzero while window not full");

  // span is never negative, so pressure sits at or above the mid price
  a_pressure_ge_mid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_levels_valid) |->
      (out_pressure_level >= {1'b0, out_mid_price}))
    else $error("pressure level below mid price");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_mid_price) && $stable(out_pressure_level)))
    else $error("stalled result beat changed");

endmodule

bind price_bar_range_and_yield pbry_chk #(
  .PRICE_BITS(PRICE_BITS)
) u_pbry_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_mid_price      (out_mid_price),
  .out_support_level  (out_support_level),
  .out_pressure_level (out_pressure_level),
  .out_levels_valid   (out_levels_valid)
);
